[rtl/rs_gf256_systematic_encoder_unit_defines.svh]
// assertion macros for the reed-solomon encoder
`ifndef RS_GF256_SYSTEMATIC_ENCODER_UNIT_DEFINES_SVH
`define RS_GF256_SYSTEMATIC_ENCODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RSENC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define RSENC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RSENC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define RSENC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/rsenc_pkg.sv]
// shared types, constants and gf(256) arithmetic for the encoder
package rsenc_pkg;

    localparam int BYTE_W        = 8;
    localparam int PCNT_W        = 6;
    localparam int RESET_PARITY  = 10;
    localparam int QDEPTH        = 2;
    localparam logic [8:0] FIELD_POLY = 9'h11D;
    localparam logic [7:0] ALPHA      = 8'h02;

    typedef enum logic
    {
        KIND_DATA = 1'b0,
        KIND_LAST = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic [BYTE_W-1:0] data;
        kind_t             kind;
    } q_item_t;

    typedef struct packed
    {
        logic    valid;
        q_item_t item;
    } q_head_t;

    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        logic [7:0] sh;
        sh = {a[6:0], 1'b0};
        return a[7] ? (sh ^ FIELD_POLY[7:0]) : sh;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = '0;
        x   = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

endpackage

[rtl/rsenc_ifs.sv]
// stream interfaces for message input and codeword output
interface rsenc_in_if;
    import rsenc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] message_byte;
    logic              final_byte;

    modport source (output valid, output message_byte, output final_byte, input ready);
    modport sink   (input valid, input message_byte, input final_byte, output ready);
endinterface

interface rsenc_out_if;
    import rsenc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] code_byte;
    logic              parity_flag;
    logic              codeword_end;

    modport source (output valid, output code_byte, output parity_flag,
                    output codeword_end, input ready);
    modport sink   (input valid, input code_byte, input parity_flag,
                    input codeword_end, output ready);
endinterface

[rtl/rsenc_gen.sv]
// generator polynomial builder, one root factor per cycle
module rsenc_gen #(
    parameter int MAX_PARITY = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [$clog2(MAX_PARITY+1)-1:0]      n_eff,
    output logic [7:0]                           coeffs [MAX_PARITY],
    output logic                                 busy
);
    import rsenc_pkg::*;

    localparam int CNT_W = $clog2(MAX_PARITY + 1);

    logic [7:0]       coef_reg  [MAX_PARITY];
    logic [7:0]       coef_next [MAX_PARITY];
    logic [7:0]       root_reg;
    logic [CNT_W-1:0] step_reg;
    logic             busy_reg;

    // multiply the running polynomial by (x + root); leading 1 is implicit
    always_comb
    begin
        for (int k = 0; k < MAX_PARITY; k++)
        begin
            if (k == 0)
            begin
                coef_next[k] = coef_reg[k] ^ root_reg;
            end
            else
            begin
                coef_next[k] = coef_reg[k] ^ gf_mul(coef_reg[k-1], root_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            root_reg <= ALPHA;
            for (int k = 0; k < MAX_PARITY; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
            root_reg <= ALPHA;
            for (int k = 0; k < MAX_PARITY; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (busy_reg)
        begin
            coef_reg <= coef_next;
            root_reg <= gf_xtime(root_reg);
            step_reg <= step_reg + 1'b1;
            if (step_reg == CNT_W'(n_eff - 1'b1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign coeffs = coef_reg;
    assign busy   = busy_reg;

endmodule

[rtl/rsenc_front.sv]
// input side: accepts and tags bytes, holds them in a two-entry queue
module rsenc_front (
    input  logic             clk,
    input  logic             rst_n,
    rsenc_in_if.sink         in_ch,
    input  logic             hold,
    input  logic             pop,
    output rsenc_pkg::q_head_t head
);
    import rsenc_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    q_item_t          fifo_mem [QDEPTH];
    q_item_t          item;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;

    assign in_ch.ready = (cnt_reg != CNT_W'(QDEPTH)) && !hold;
    assign push        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        item.data = in_ch.message_byte;
        item.kind = in_ch.final_byte ? KIND_LAST : KIND_DATA;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.item  = fifo_mem[rd_ptr_reg];

endmodule

[rtl/rsenc_back.sv]
// output side: remainder lfsr, pass-through and parity shift-out
module rsenc_back #(
    parameter int MAX_PARITY = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             clear,
    input  logic [$clog2(MAX_PARITY+1)-1:0]  n_eff,
    input  logic [7:0]                       coeffs [MAX_PARITY],
    input  rsenc_pkg::q_head_t               head,
    output logic                             pop,
    rsenc_out_if.source                      out_ch
);
    import rsenc_pkg::*;

    localparam int CNT_W = $clog2(MAX_PARITY + 1);

    typedef enum logic [1:0]
    {
        ST_DATA = 2'b01,
        ST_PAR  = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [7:0]        rem_reg   [MAX_PARITY];
    logic [7:0]        rem_next  [MAX_PARITY];
    logic [7:0]        lfsr_next [MAX_PARITY];
    logic [7:0]        shift_next[MAX_PARITY];
    logic [7:0]        fb;
    logic [CNT_W-1:0]  pcnt_reg, pcnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] code_reg, code_next;
    logic              par_reg, par_next;
    logic              end_reg, end_next;
    logic              slot_free;
    logic              last_par;

    assign fb        = head.item.data ^ rem_reg[0];
    assign slot_free = !out_valid_reg || out_ch.ready;
    assign pop       = (state_reg == ST_DATA) && head.valid && slot_free;
    assign last_par  = (pcnt_reg == CNT_W'(n_eff - 1'b1));

    // entries at or above n stay zero, so the full-length lfsr matches degree n
    always_comb
    begin
        for (int j = 0; j < MAX_PARITY; j++)
        begin
            if (j + 1 < MAX_PARITY)
            begin
                shift_next[j] = rem_reg[j+1];
            end
            else
            begin
                shift_next[j] = '0;
            end
            lfsr_next[j] = shift_next[j] ^ gf_mul(coeffs[j], fb);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        pcnt_next      = pcnt_reg;
        out_valid_next = out_valid_reg;
        code_next      = code_reg;
        par_next       = par_reg;
        end_next       = end_reg;
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_DATA:
            begin
                if (pop)
                begin
                    rem_next       = lfsr_next;
                    out_valid_next = 1'b1;
                    code_next      = head.item.data;
                    par_next       = 1'b0;
                    end_next       = 1'b0;
                    if (head.item.kind == KIND_LAST)
                    begin
                        state_next = ST_PAR;
                        pcnt_next  = '0;
                    end
                end
            end
            ST_PAR:
            begin
                // shifting zeros in leaves the remainder clear at the end
                if (slot_free)
                begin
                    rem_next       = shift_next;
                    out_valid_next = 1'b1;
                    code_next      = rem_reg[0];
                    par_next       = 1'b1;
                    end_next       = last_par;
                    pcnt_next      = pcnt_reg + 1'b1;
                    if (last_par)
                    begin
                        state_next = ST_DATA;
                    end
                end
            end
            default:
            begin
                state_next = ST_DATA;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_DATA;
            pcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < MAX_PARITY; j++)
            begin
                rem_reg[j] <= '0;
            end
        end
        else if (clear)
        begin
            state_reg     <= ST_DATA;
            pcnt_reg      <= '0;
            out_valid_reg <= out_valid_next;
            for (int j = 0; j < MAX_PARITY; j++)
            begin
                rem_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pcnt_reg      <= pcnt_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        par_reg  <= par_next;
        end_reg  <= end_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.code_byte    = code_reg;
    assign out_ch.parity_flag  = par_reg;
    assign out_ch.codeword_end = end_reg;

endmodule

[rtl/rs_gf256_systematic_encoder_unit.sv]
// a message byte passes through the input queue and then the output register
// throughput, unless the output stalls: one message byte per cycle, and after a
//   final byte n parity bytes, one per cycle, while no bytes leave the queue
// after reset or a parity_count write the input stalls while the generator is
//   rebuilt one root per cycle (n = 10 after reset)
// reset: asynchronous active low, clears the remainder, queue and output stage
`include "rs_gf256_systematic_encoder_unit_defines.svh"

module rs_gf256_systematic_encoder_unit #(
    parameter int MAX_PARITY = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [rsenc_pkg::PCNT_W-1:0] cfg_wr_data,
    rsenc_in_if.sink                    in_ch,
    rsenc_out_if.source                 out_ch
);
    import rsenc_pkg::*;

    localparam int CNT_W   = $clog2(MAX_PARITY + 1);
    localparam int RESET_N = (MAX_PARITY < RESET_PARITY) ? MAX_PARITY : RESET_PARITY;

    logic [CNT_W-1:0] parity_reg;
    logic [CNT_W-1:0] parity_next;
    logic [7:0]       coeffs [MAX_PARITY];
    logic             gen_busy;
    logic             pop;
    q_head_t          head;

    // zero acts as one, large values saturate
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            parity_next = CNT_W'(1);
        end
        else if (int'(cfg_wr_data) > MAX_PARITY)
        begin
            parity_next = CNT_W'(MAX_PARITY);
        end
        else
        begin
            parity_next = CNT_W'(cfg_wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= CNT_W'(RESET_N);
        end
        else if (cfg_wr_en)
        begin
            parity_reg <= parity_next;
        end
    end

    rsenc_gen #(
        .MAX_PARITY (MAX_PARITY)
    ) u_gen (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_wr_en),
        .n_eff  (parity_reg),
        .coeffs (coeffs),
        .busy   (gen_busy)
    );

    rsenc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .hold  (gen_busy),
        .pop   (pop),
        .head  (head)
    );

    rsenc_back #(
        .MAX_PARITY (MAX_PARITY)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (cfg_wr_en),
        .n_eff  (parity_reg),
        .coeffs (coeffs),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

    `RSENC_ASSERT_NXT(a_cfg_blocks_input, clk, rst_n, cfg_wr_en, !in_ch.ready, "input ready right after a config write")
    `RSENC_ASSERT_IMP(a_end_is_parity, clk, rst_n, out_ch.valid && out_ch.codeword_end, out_ch.parity_flag, "codeword end on a non-parity word")
    `RSENC_ASSERT_NXT(a_data_after_end, clk, rst_n, out_ch.valid && out_ch.ready && out_ch.codeword_end, !(out_ch.valid && out_ch.parity_flag), "parity word follows codeword end")

endmodule

[tb/rs_codeword_checker.sv]
// codeword predictor and output checker for the reed-solomon encoder
module rs_codeword_checker #(
    parameter int MAX_PARITY = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [rsenc_pkg::PCNT_W-1:0] cfg_wr_data,
    rsenc_in_if                          in_ch,
    rsenc_out_if                         out_ch,
    output int                           error_count,
    output int                           words_pending,
    output int                           words_checked,
    output int                           parity_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import rsenc_pkg::*;

    typedef struct packed
    {
        logic [7:0] code;
        logic       parity;
        logic       last;
    } code_word_t;

    code_word_t expected_words[$];
    logic [7:0] gen_poly [MAX_PARITY];
    logic [7:0] lfsr     [MAX_PARITY];
    int         n_parity;

    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] acc;
        acc = '0;
        x   = {1'b0, a};
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc ^= x[7:0];
            end
            x = x << 1;
            if (x[8])
            begin
                x ^= FIELD_POLY;
            end
        end
        return acc;
    endfunction

    // zero acts as one, anything above the maximum saturates
    function automatic int clamp_parity(input logic [PCNT_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > MAX_PARITY)
        begin
            return MAX_PARITY;
        end
        return int'(v);
    endfunction

    // g(x) = (x + a^1)...(x + a^n), leading one dropped; also clears the remainder
    function automatic void load_generator(input logic [PCNT_W-1:0] v);
        logic [7:0] full [MAX_PARITY+1];
        logic [7:0] root;
        n_parity = clamp_parity(v);
        foreach (full[i])
        begin
            full[i] = 8'h00;
        end
        full[0] = 8'h01;
        root    = 8'h01;
        for (int i = 0; i < n_parity; i++)
        begin
            root = gf_times(root, ALPHA);
            for (int j = i + 1; j >= 1; j--)
            begin
                full[j] ^= gf_times(full[j-1], root);
            end
        end
        for (int k = 0; k < MAX_PARITY; k++)
        begin
            gen_poly[k] = (k < n_parity) ? full[k+1] : 8'h00;
            lfsr[k]     = 8'h00;
        end
    endfunction

    function automatic void encode_byte(input logic [7:0] d, input logic fin);
        logic [7:0] fb;
        code_word_t w;
        fb = d ^ lfsr[0];
        for (int j = 0; j + 1 < n_parity; j++)
        begin
            lfsr[j] = lfsr[j+1] ^ gf_times(gen_poly[j], fb);
        end
        lfsr[n_parity-1] = gf_times(gen_poly[n_parity-1], fb);
        w.code   = d;
        w.parity = 1'b0;
        w.last   = 1'b0;
        expected_words.push_back(w);
        if (fin)
        begin
            // parity follows highest order first, then the remainder starts over
            for (int j = 0; j < n_parity; j++)
            begin
                w.code   = lfsr[j];
                w.parity = 1'b1;
                w.last   = (j == n_parity - 1);
                expected_words.push_back(w);
            end
            for (int j = 0; j < MAX_PARITY; j++)
            begin
                lfsr[j] = 8'h00;
            end
        end
    endfunction

    function automatic void check_word(input logic [7:0] code, input logic par, input logic fin);
        code_word_t want;
        if (expected_words.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
            begin
                $display("%0t: unexpected word code=%02h parity=%b end=%b",
                         $realtime, code, par, fin);
            end
            return;
        end
        want = expected_words.pop_front();
        words_checked++;
        if (want.parity)
        begin
            parity_checked++;
        end
        if (want.code !== code || want.parity !== par || want.last !== fin)
        begin
            error_count++;
            if (error_count <= 10)
            begin
                $display("%0t: word mismatch, expected code=%02h parity=%b end=%b, got code=%02h parity=%b end=%b",
                         $realtime, want.code, want.parity, want.last, code, par, fin);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            load_generator(PCNT_W'(RESET_PARITY));
            error_count    = 0;
            words_checked  = 0;
            parity_checked = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                check_word(out_ch.code_byte, out_ch.parity_flag, out_ch.codeword_end);
            end
            if (cfg_wr_en)
            begin
                load_generator(cfg_wr_data);
            end
            if (in_ch.valid && in_ch.ready)
            begin
                encode_byte(in_ch.message_byte, in_ch.final_byte);
            end
        end
        words_pending = expected_words.size();
    end

endmodule

[tb/tb_rs_gf256_systematic_encoder_unit.sv]
// stimulus, clock, reset and verdict for the reed-solomon encoder
module tb_rs_gf256_systematic_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PAR    = 32;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_ITEMS = 33;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [rsenc_pkg::PCNT_W-1:0]  cfg_wr_data = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;
    int messages_sent  = 0;
    int bytes_sent     = 0;
    int settings_used  = 1;
    int error_count;
    int words_pending;
    int words_checked;
    int parity_checked;

    rsenc_in_if  in_ch();
    rsenc_out_if out_ch();

    rs_gf256_systematic_encoder_unit #(
        .MAX_PARITY (MAX_PAR)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    rs_codeword_checker #(
        .MAX_PARITY (MAX_PAR)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .error_count    (error_count),
        .words_pending  (words_pending),
        .words_checked  (words_checked),
        .parity_checked (parity_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // nothing moved on either channel for too long
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 10)
        begin
            return 8'h00;
        end
        if (r < 20)
        begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.message_byte <= b;
        in_ch.final_byte   <= fin;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        if (fin)
        begin
            messages_sent++;
        end
    endtask

    task automatic drain_words();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_parity(input logic [rsenc_pkg::PCNT_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [rsenc_pkg::PCNT_W-1:0] parity_plan [6];
        logic [rsenc_pkg::PCNT_W-1:0] pc;
        int r;
        int msg_len;
        int phase_items;

        in_ch.valid        = 1'b0;
        in_ch.message_byte = '0;
        in_ch.final_byte   = 1'b0;
        out_ch.ready       = 1'b0;
        // zero acts as one, 63 and 33 saturate to the maximum
        parity_plan = '{6'd0, 6'd63, 6'd32, 6'd1, 6'd33, 6'd2};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset parity count: single-byte messages, walking one, all-ones run
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        for (int i = 0; i < 8; i++)
        begin
            send_byte(8'h01 << i, i == 7);
        end
        repeat (3) send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // unfinished message, dropped by the parity_count write that follows
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hC3, 1'b0);
        drain_words();

        for (int s = 0; s < 8; s++)
        begin
            pc = (s < 6) ? parity_plan[s] : rsenc_pkg::PCNT_W'($urandom_range(31, 3));
            write_parity(pc);
            case (s % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 83;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 83;
                end
                default:
                begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    msg_len = $urandom_range(8, 1);
                end
                else if (r < 95)
                begin
                    msg_len = $urandom_range(24, 9);
                end
                else
                begin
                    msg_len = $urandom_range(60, 25);
                end
                for (int k = 0; k < msg_len; k++)
                begin
                    send_byte(pick_byte(), k == msg_len - 1);
                end
                phase_items += msg_len;
            end
            // sometimes leave a message open across the next parity_count write
            if ($urandom_range(1) == 1)
            begin
                repeat ($urandom_range(3, 1)) send_byte(pick_byte(), 1'b0);
            end
            drain_words();
        end

        repeat (20) @(posedge clk);
        $display("sent %0d bytes in %0d complete messages across %0d parity settings",
                 bytes_sent, messages_sent, settings_used);
        $display("checked %0d output words, %0d of them parity, under four idle mixes",
                 words_checked, parity_checked);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[rs_gf256_systematic_encoder_unit.f]
+incdir+rtl
rtl/rsenc_pkg.sv
rtl/rsenc_ifs.sv
rtl/rsenc_gen.sv
rtl/rsenc_front.sv
rtl/rsenc_back.sv
rtl/rs_gf256_systematic_encoder_unit.sv
tb/rs_codeword_checker.sv
tb/tb_rs_gf256_systematic_encoder_unit.sv
